@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/wcg_pkg.sv @@
// ---------------------------------------------------------------------------
// wcg_pkg
// Types, constants and pipeline depths of the window coefficient generator.
// ---------------------------------------------------------------------------
package wcg_pkg;

  // Frame and result format
  localparam int unsigned MAX_SIZE_LOG2  = 16;
  localparam int unsigned MIN_SIZE_LOG2  = 4;
  localparam int unsigned COEF_FRAC_BITS = 15;
  localparam int unsigned RND_SHIFT      = 60 - COEF_FRAC_BITS;

  localparam logic [4:0]  LOG2_MIN  = 5'(MIN_SIZE_LOG2);
  localparam logic [4:0]  LOG2_MAX  = 5'(MAX_SIZE_LOG2);
  localparam logic [15:0] COEF_ONE  = 16'(1 << COEF_FRAC_BITS);
  localparam logic [63:0] RND_ADD   = 64'(64'd1 << (RND_SHIFT - 1));

  // Fixed-point ones and half pi
  localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
  localparam logic signed [63:0] ONE_Q60   = 64'sh1000_0000_0000_0000;
  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;

  // Window constants, Q30
  localparam logic [29:0] C_054 = 30'd579820585;
  localparam logic [29:0] C_046 = 30'd493921239;
  localparam logic [29:0] C_050 = 30'd536870912;
  localparam logic [29:0] C_042 = 30'd450971566;
  localparam logic [29:0] C_008 = 30'd85899346;
  localparam logic [29:0] C_BH0 = 30'd385204879;
  localparam logic [29:0] C_BH1 = 30'd524297395;
  localparam logic [29:0] C_BH2 = 30'd151698245;
  localparam logic [29:0] C_BH3 = 30'd12541305;

  // Window kinds
  typedef enum logic [2:0] {
    WIN_HAMMING  = 3'd0,
    WIN_HANN     = 3'd1,
    WIN_BLACKMAN = 3'd2,
    WIN_BH       = 3'd3,
    WIN_GAUSS    = 3'd4,
    WIN_WELCH    = 3'd5,
    WIN_PARZEN   = 3'd6,
    WIN_RECT     = 3'd7
  } win_kind_t;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_KIND     = 2'd0;
  localparam logic [1:0] REG_WINDOW_SPAN     = 2'd1;
  localparam logic [1:0] REG_FRAME_SIZE_LOG2 = 2'd2;

  // Pipelined divider: numerator bits, divisor bits, bits retired per stage
  localparam int unsigned DIV_NUM_W = 50;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned DIV_BPS   = 2;
  localparam int unsigned DIV_LAT   = DIV_NUM_W / DIV_BPS;

  // Series evaluation: one Horner step is three stages
  localparam int unsigned HSTEP_LAT = 3;
  localparam int unsigned COS_STEPS = 7;
  localparam int unsigned EXP_STEPS = 12;
  localparam int unsigned COS_LAT   = 3 + COS_STEPS * HSTEP_LAT;
  localparam int unsigned EXP_LAT   = EXP_STEPS * HSTEP_LAT;

  // Alignment, counted from the front register
  localparam int unsigned HARM_OFS = DIV_LAT + COS_LAT;
  localparam int unsigned RAT_DLY  = COS_LAT;
  localparam int unsigned GAU_DLY  = HARM_OFS - 2 - EXP_LAT;
  localparam int unsigned FLG_DLY  = HARM_OFS;
  localparam int unsigned PIPE_LAT = HARM_OFS + 4;

  // Reciprocals for division by small constants
  localparam logic [32:0] MAG_NUM = 33'h0_FFFF_FFFF;

  localparam logic [7:0] COS_DIV [COS_STEPS] =
    '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] COS_MAG [COS_STEPS] = '{
    32'(MAG_NUM / 182), 32'(MAG_NUM / 132), 32'(MAG_NUM / 90), 32'(MAG_NUM / 56),
    32'(MAG_NUM / 30), 32'(MAG_NUM / 12), 32'(MAG_NUM / 2)};

  localparam logic [7:0] EXP_DIV [EXP_STEPS] = '{
    8'd12, 8'd11, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1};
  localparam logic [31:0] EXP_MAG [EXP_STEPS] = '{
    32'(MAG_NUM / 12), 32'(MAG_NUM / 11), 32'(MAG_NUM / 10), 32'(MAG_NUM / 9),
    32'(MAG_NUM / 8), 32'(MAG_NUM / 7), 32'(MAG_NUM / 6), 32'(MAG_NUM / 5),
    32'(MAG_NUM / 4), 32'(MAG_NUM / 3), 32'(MAG_NUM / 2), 32'(MAG_NUM / 1)};

endpackage

@@ hdl/wcg_div.sv @@
// ---------------------------------------------------------------------------
// wcg_div
// Pipelined restoring divider, two quotient bits per stage, one item a cycle.
// ---------------------------------------------------------------------------
module wcg_div (
  input  logic                           clk,
  input  logic [wcg_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [wcg_pkg::DIV_DEN_W-1:0]  den_i,
  output logic [wcg_pkg::DIV_NUM_W-1:0]  quo_o
);

  localparam int unsigned NW = wcg_pkg::DIV_NUM_W;
  localparam int unsigned DW = wcg_pkg::DIV_DEN_W;
  localparam int unsigned NS = wcg_pkg::DIV_LAT;

  // word holds unconsumed numerator bits on top, quotient bits filling in below
  logic [DW-1:0] rem_r [NS];
  logic [NW-1:0] wrd_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [DW-1:0] rem_nxt [NS];
  logic [NW-1:0] wrd_nxt [NS];
  logic [DW-1:0] rem_in [NS];
  logic [NW-1:0] wrd_in [NS];
  logic [DW-1:0] den_in [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic [DW:0]   trial;
    logic [DW-1:0] rem_v;
    logic [NW-1:0] wrd_v;
    logic          qb;

    if (s == 0) begin : g_first
      assign rem_in[s] = '0;
      assign wrd_in[s] = num_i;
      assign den_in[s] = den_i;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign wrd_in[s] = wrd_r[s-1];
      assign den_in[s] = den_r[s-1];
    end

    // shift-subtract, one quotient bit per pass
    always_comb begin
      rem_v = rem_in[s];
      wrd_v = wrd_in[s];
      trial = '0;
      qb    = 1'b0;
      for (int b = 0; b < wcg_pkg::DIV_BPS; b++) begin
        trial = {rem_v, wrd_v[NW-1]};
        qb    = (trial >= {1'b0, den_in[s]});
        if (qb) begin
          trial = trial - {1'b0, den_in[s]};
        end
        rem_v = trial[DW-1:0];
        wrd_v = {wrd_v[NW-2:0], qb};
      end
      rem_nxt[s] = rem_v;
      wrd_nxt[s] = wrd_v;
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt[s];
      wrd_r[s] <= wrd_nxt[s];
      den_r[s] <= den_in[s];
    end
  end

  assign quo_o = wrd_r[NS-1];

endmodule

@@ hdl/wcg_hstep.sv @@
// ---------------------------------------------------------------------------
// wcg_hstep
// One Horner step c' = 1 - ((a*c) >> 30) / k in Q30, three register stages.
// ---------------------------------------------------------------------------
module wcg_hstep (
  input  logic        clk,
  input  logic [31:0] a_i,
  input  logic [30:0] c_i,
  input  logic [7:0]  div_c,
  input  logic [31:0] div_m,
  output logic [31:0] a_o,
  output logic [30:0] c_o
);

  logic [62:0] pa_prod;
  logic [31:0] p_a_r, a_a_r;
  logic [63:0] qb_prod;
  logic [31:0] p_b_r, a_b_r, q_b_r;
  logic [39:0] qc_prod;
  logic [39:0] diff;
  logic [31:0] term;
  logic [30:0] c_nxt;
  logic [31:0] a_c_r;
  logic [30:0] c_c_r;

  // stage a: product, back to Q30
  assign pa_prod = a_i * c_i;

  // stage b: estimate quotient by reciprocal
  assign qb_prod = p_a_r * div_m;

  // stage c: at most two corrections, then 1 - term
  assign qc_prod = q_b_r * div_c;
  assign diff    = {8'd0, p_b_r} - qc_prod;
  always_comb begin
    term = q_b_r + 32'(diff >= 40'(div_c)) + 32'(diff >= (40'(div_c) << 1));
    if (term >= 32'(wcg_pkg::ONE_Q30)) begin
      c_nxt = '0;
    end else begin
      c_nxt = 31'(32'(wcg_pkg::ONE_Q30) - term);
    end
  end

  always_ff @(posedge clk) begin
    p_a_r <= pa_prod[61:30];
    a_a_r <= a_i;
    p_b_r <= p_a_r;
    a_b_r <= a_a_r;
    q_b_r <= qb_prod[63:32];
    a_c_r <= a_b_r;
    c_c_r <= c_nxt;
  end

  assign a_o = a_c_r;
  assign c_o = c_c_r;

endmodule

@@ hdl/wcg_cos.sv @@
// ---------------------------------------------------------------------------
// wcg_cos
// Cosine of a 32-bit turn fraction in Q30: quadrant fold, angle scaling and
// a Taylor series to x^14 evaluated by a chain of Horner steps.
// ---------------------------------------------------------------------------
module wcg_cos (
  input  logic               clk,
  input  logic [31:0]        t_i,
  output logic signed [31:0] cos_o
);

  localparam int unsigned NS = wcg_pkg::COS_STEPS;

  logic [32:0] u0, u1;
  logic        neg;
  logic [30:0] u_r;
  logic [61:0] x_prod;
  logic [30:0] x_r;
  logic [61:0] x2_prod;
  logic [31:0] x2_r;
  logic        neg_r [wcg_pkg::COS_LAT];
  logic [31:0] a_ch [NS];
  logic [30:0] c_ch [NS+1];
  logic signed [31:0] c_pos;

  // fold onto the first quadrant, remember the sign
  always_comb begin
    u0  = t_i[31] ? (33'h1_0000_0000 - {1'b0, t_i}) : {1'b0, t_i};
    neg = 1'b0;
    u1  = u0;
    if (u0 > 33'(wcg_pkg::ONE_Q30)) begin
      u1  = 33'h0_8000_0000 - u0;
      neg = 1'b1;
    end
  end

  assign x_prod  = u_r * wcg_pkg::HALF_PI_Q30;
  assign x2_prod = x_r * x_r;

  always_ff @(posedge clk) begin
    u_r  <= u1[30:0];
    x_r  <= x_prod[60:30];
    x2_r <= x2_prod[61:30];
    neg_r[0] <= neg;
    for (int i = 1; i < wcg_pkg::COS_LAT; i++) begin
      neg_r[i] <= neg_r[i-1];
    end
  end

  // Horner chain, highest term first
  assign a_ch[0] = x2_r;
  assign c_ch[0] = wcg_pkg::ONE_Q30;

  for (genvar g = 0; g < NS; g++) begin : g_step
    if (g < NS - 1) begin : g_mid
      wcg_hstep u_hstep (
        .clk   (clk),
        .a_i   (a_ch[g]),
        .c_i   (c_ch[g]),
        .div_c (wcg_pkg::COS_DIV[g]),
        .div_m (wcg_pkg::COS_MAG[g]),
        .a_o   (a_ch[g+1]),
        .c_o   (c_ch[g+1])
      );
    end else begin : g_last
      wcg_hstep u_hstep (
        .clk   (clk),
        .a_i   (a_ch[g]),
        .c_i   (c_ch[g]),
        .div_c (wcg_pkg::COS_DIV[g]),
        .div_m (wcg_pkg::COS_MAG[g]),
        .a_o   (),
        .c_o   (c_ch[g+1])
      );
    end
  end

  assign c_pos = {1'b0, c_ch[NS]};
  assign cos_o = neg_r[wcg_pkg::COS_LAT-1] ? -c_pos : c_pos;

endmodule

@@ hdl/wcg_exp.sv @@
// ---------------------------------------------------------------------------
// wcg_exp
// exp(-a) in Q30 for a up to 1.0, Taylor series to a^12 as Horner steps.
// ---------------------------------------------------------------------------
module wcg_exp (
  input  logic        clk,
  input  logic [30:0] a_i,
  output logic [30:0] e_o
);

  localparam int unsigned NS = wcg_pkg::EXP_STEPS;

  logic [31:0] a_ch [NS];
  logic [30:0] c_ch [NS+1];

  assign a_ch[0] = {1'b0, a_i};
  assign c_ch[0] = wcg_pkg::ONE_Q30;

  for (genvar g = 0; g < NS; g++) begin : g_step
    if (g < NS - 1) begin : g_mid
      wcg_hstep u_hstep (
        .clk   (clk),
        .a_i   (a_ch[g]),
        .c_i   (c_ch[g]),
        .div_c (wcg_pkg::EXP_DIV[g]),
        .div_m (wcg_pkg::EXP_MAG[g]),
        .a_o   (a_ch[g+1]),
        .c_o   (c_ch[g+1])
      );
    end else begin : g_last
      wcg_hstep u_hstep (
        .clk   (clk),
        .a_i   (a_ch[g]),
        .c_i   (c_ch[g]),
        .div_c (wcg_pkg::EXP_DIV[g]),
        .div_m (wcg_pkg::EXP_MAG[g]),
        .a_o   (),
        .c_o   (c_ch[g+1])
      );
    end
  end

  assign e_o = c_ch[NS];

endmodule

@@ hdl/fft_window_coefficient_generator.sv @@
// ---------------------------------------------------------------------------
// fft_window_coefficient_generator
// Analysis window coefficient at a frame index, unsigned Q1.15, as a pipeline.
// ---------------------------------------------------------------------------
//  channel   direction  ports                                    handshake
//  in        input      in_sample_index                          start, busy
//  out       output     out_coefficient, out_in_padding,         out_strobe
//                       out_out_of_range
//  cfg       input      cfg_index, cfg_wdata                     cfg_we
//
//  One item accepted every cycle while busy is low; its result goes through
//  the front register, 25-stage divider, 24-stage cosine unit and F1-F3.
//  busy is high only during reset and the cycle after it.
//  rst_n is synchronous; it drops all items in flight and resets cfg registers.
//  Results are shown for one cycle under out_strobe and are never held off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fft_window_coefficient_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_sample_index,
  output logic        out_strobe,
  output logic [15:0] out_coefficient,
  output logic        out_in_padding,
  output logic        out_out_of_range,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int unsigned NW = wcg_pkg::DIV_NUM_W;
  localparam int unsigned DW = wcg_pkg::DIV_DEN_W;

  // Configuration registers
  wcg_pkg::win_kind_t kind_r;
  logic [1:0]         span_r;
  logic [4:0]         fsl_r;
  logic               busy_r;
  logic               acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= wcg_pkg::WIN_HAMMING;
      span_r <= '0;
      fsl_r  <= 5'd9;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          wcg_pkg::REG_WINDOW_KIND:     kind_r <= wcg_pkg::win_kind_t'(cfg_wdata[2:0]);
          wcg_pkg::REG_WINDOW_SPAN:     span_r <= cfg_wdata[1:0];
          wcg_pkg::REG_FRAME_SIZE_LOG2: fsl_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  // Frame geometry from configuration
  logic [4:0]  lg_c, m_c;
  logic [16:0] n_c, w_c, wp1_c;
  logic [15:0] p_c, wm1_c;

  always_comb begin
    if (fsl_r < wcg_pkg::LOG2_MIN) begin
      lg_c = wcg_pkg::LOG2_MIN;
    end else if (fsl_r > wcg_pkg::LOG2_MAX) begin
      lg_c = wcg_pkg::LOG2_MAX;
    end else begin
      lg_c = fsl_r;
    end
    m_c   = lg_c - 5'(span_r);
    n_c   = 17'd1 << lg_c;
    w_c   = 17'd1 << m_c;
    p_c   = 16'((n_c - w_c) >> 1);
    wm1_c = 16'(w_c - 17'd1);
    wp1_c = w_c + 17'd1;
  end

  // Front stage: range, padding, local index and distance from centre
  logic        oor_c, pad_c;
  logic [15:0] j_c;
  logic [16:0] twoj_c, d_c;
  logic        s1_vld_r, s1_oor_r, s1_pad_r;
  logic [15:0] s1_j_r;
  logic [16:0] s1_d_r;

  always_comb begin
    oor_c  = ({1'b0, in_sample_index} >= n_c);
    pad_c  = !oor_c && ((in_sample_index < p_c) ||
                        ({1'b0, in_sample_index} >= ({1'b0, p_c} + w_c)));
    j_c    = in_sample_index - p_c;
    twoj_c = {j_c, 1'b0};
    d_c    = (twoj_c >= w_c) ? (twoj_c - w_c) : (w_c - twoj_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_oor_r <= oor_c;
    s1_pad_r <= pad_c;
    s1_j_r   <= j_c;
    s1_d_r   <= d_c;
  end

  // Harmonic angles k*j/(W-1) turns and ratio d/(W+1), through dividers
  logic [17:0]   kj1, kj2, kj3;
  logic [NW-1:0] num1, num2, num3, numr;
  logic [NW-1:0] quo1, quo2, quo3, quor;
  logic [DW-1:0] den_h;

  assign kj1   = {2'b00, s1_j_r};
  assign kj2   = {1'b0, s1_j_r, 1'b0};
  assign kj3   = kj1 + kj2;
  assign den_h = {1'b0, wm1_c};
  assign num1  = {kj1, 32'd0} | NW'(wm1_c >> 1);
  assign num2  = {kj2, 32'd0} | NW'(wm1_c >> 1);
  assign num3  = {kj3, 32'd0} | NW'(wm1_c >> 1);
  assign numr  = {3'b000, s1_d_r, 30'd0} | NW'(wp1_c >> 1);

  wcg_div u_div1 (.clk(clk), .num_i(num1), .den_i(den_h), .quo_o(quo1));
  wcg_div u_div2 (.clk(clk), .num_i(num2), .den_i(den_h), .quo_o(quo2));
  wcg_div u_div3 (.clk(clk), .num_i(num3), .den_i(den_h), .quo_o(quo3));
  wcg_div u_divr (.clk(clk), .num_i(numr), .den_i(wp1_c), .quo_o(quor));

  // Cosines of the three harmonics
  logic signed [31:0] h1, h2, h3;

  wcg_cos u_cos1 (.clk(clk), .t_i(quo1[31:0]), .cos_o(h1));
  wcg_cos u_cos2 (.clk(clk), .t_i(quo2[31:0]), .cos_o(h2));
  wcg_cos u_cos3 (.clk(clk), .t_i(quo3[31:0]), .cos_o(h3));

  // Gaussian: r = round(d/W) by shift, squared, then exp(-a)
  logic [46:0] gtmp;
  logic [30:0] gr_r, ga_r, e_c;
  logic [61:0] ga_prod;

  assign gtmp    = {s1_d_r, 30'd0} + 47'(w_c >> 1);
  assign ga_prod = gr_r * gr_r;

  always_ff @(posedge clk) begin
    gr_r <= 31'(gtmp >> m_c);
    ga_r <= ga_prod[60:30];
  end

  wcg_exp u_exp (.clk(clk), .a_i(ga_r), .e_o(e_c));

  // Alignment lines to the cosine outputs
  logic [30:0] rat_dly_r [wcg_pkg::RAT_DLY];
  logic [30:0] gau_dly_r [wcg_pkg::GAU_DLY];
  logic [1:0]  flg_dly_r [wcg_pkg::FLG_DLY];
  logic        vld_dly_r [wcg_pkg::FLG_DLY];

  always_ff @(posedge clk) begin
    rat_dly_r[0] <= quor[30:0];
    for (int i = 1; i < wcg_pkg::RAT_DLY; i++) begin
      rat_dly_r[i] <= rat_dly_r[i-1];
    end
    gau_dly_r[0] <= e_c;
    for (int i = 1; i < wcg_pkg::GAU_DLY; i++) begin
      gau_dly_r[i] <= gau_dly_r[i-1];
    end
    flg_dly_r[0] <= {s1_oor_r, s1_pad_r};
    for (int i = 1; i < wcg_pkg::FLG_DLY; i++) begin
      flg_dly_r[i] <= flg_dly_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wcg_pkg::FLG_DLY; i++) begin
        vld_dly_r[i] <= 1'b0;
      end
    end else begin
      vld_dly_r[0] <= s1_vld_r;
      for (int i = 1; i < wcg_pkg::FLG_DLY; i++) begin
        vld_dly_r[i] <= vld_dly_r[i-1];
      end
    end
  end

  // Cosine-sum weights per window kind
  logic [29:0] a0_c, a1_c, a2_c, a3_c;

  always_comb begin
    unique case (kind_r)
      wcg_pkg::WIN_HANN: begin
        a0_c = wcg_pkg::C_050; a1_c = wcg_pkg::C_050; a2_c = '0; a3_c = '0;
      end
      wcg_pkg::WIN_BLACKMAN: begin
        a0_c = wcg_pkg::C_042; a1_c = wcg_pkg::C_050; a2_c = wcg_pkg::C_008; a3_c = '0;
      end
      wcg_pkg::WIN_BH: begin
        a0_c = wcg_pkg::C_BH0; a1_c = wcg_pkg::C_BH1;
        a2_c = wcg_pkg::C_BH2; a3_c = wcg_pkg::C_BH3;
      end
      default: begin
        a0_c = wcg_pkg::C_054; a1_c = wcg_pkg::C_046; a2_c = '0; a3_c = '0;
      end
    endcase
  end

  // F1: weighted harmonics and squares
  logic signed [31:0] a1_s, a2_s, a3_s;
  logic signed [63:0] p1_c, p2_c, p3_c;
  logic signed [63:0] p1_r, p2_r, p3_r;
  logic [61:0]        sq_c, sq_r;
  logic [30:0]        rw_r, e_r;
  logic               f1_vld_r, f1_oor_r, f1_pad_r;

  assign a1_s = {2'b00, a1_c};
  assign a2_s = {2'b00, a2_c};
  assign a3_s = {2'b00, a3_c};
  assign p1_c = a1_s * h1;
  assign p2_c = a2_s * h2;
  assign p3_c = a3_s * h3;
  assign sq_c = rat_dly_r[wcg_pkg::RAT_DLY-1] * rat_dly_r[wcg_pkg::RAT_DLY-1];

  always_ff @(posedge clk) begin
    p1_r     <= p1_c;
    p2_r     <= p2_c;
    p3_r     <= p3_c;
    sq_r     <= sq_c;
    rw_r     <= rat_dly_r[wcg_pkg::RAT_DLY-1];
    e_r      <= gau_dly_r[wcg_pkg::GAU_DLY-1];
    f1_oor_r <= flg_dly_r[wcg_pkg::FLG_DLY-1][1];
    f1_pad_r <= flg_dly_r[wcg_pkg::FLG_DLY-1][0];
  end

  // F2: Q60 window value
  logic signed [63:0] v_nxt, v_r;
  logic               f2_vld_r, f2_oor_r, f2_pad_r;

  always_comb begin
    unique case (kind_r)
      wcg_pkg::WIN_GAUSS:  v_nxt = $signed({3'b000, e_r, 30'd0});
      wcg_pkg::WIN_WELCH:  v_nxt = wcg_pkg::ONE_Q60 - $signed({2'b00, sq_r});
      wcg_pkg::WIN_PARZEN: v_nxt = wcg_pkg::ONE_Q60 - $signed({3'b000, rw_r, 30'd0});
      wcg_pkg::WIN_RECT:   v_nxt = wcg_pkg::ONE_Q60;
      default:             v_nxt = $signed({4'd0, a0_c, 30'd0}) - p1_r + p2_r - p3_r;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    f2_oor_r <= f1_oor_r;
    f2_pad_r <= f1_pad_r;
  end

  // F3: round half up to Q1.15, clamp, flags force zero
  logic [63:0] rsum;
  logic [18:0] rq;
  logic [15:0] coef_nxt;
  logic [15:0] coef_r;
  logic        oor_r, pad_r, strobe_r;

  assign rsum = $unsigned(v_r) + wcg_pkg::RND_ADD;
  assign rq   = 19'(rsum >> wcg_pkg::RND_SHIFT);

  always_comb begin
    if (f2_oor_r || f2_pad_r || (v_r <= 64'sd0)) begin
      coef_nxt = '0;
    end else if (rq > 19'(wcg_pkg::COEF_ONE)) begin
      coef_nxt = wcg_pkg::COEF_ONE;
    end else begin
      coef_nxt = rq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    oor_r  <= f2_oor_r;
    pad_r  <= f2_pad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      f1_vld_r <= vld_dly_r[wcg_pkg::FLG_DLY-1];
      f2_vld_r <= f1_vld_r;
      strobe_r <= f2_vld_r;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_coefficient  = coef_r;
  assign out_in_padding   = pad_r;
  assign out_out_of_range = oor_r;

  // Checks
  `ASSERT_IMP(a_flags_excl, clk, rst_n, out_strobe, !(out_in_padding && out_out_of_range))
  `ASSERT_IMP(a_flag_zero, clk, rst_n, strobe_r && (pad_r || oor_r), coef_r == 16'd0)
  `ASSERT_IMP(a_coef_max, clk, rst_n, out_strobe, out_coefficient <= wcg_pkg::COEF_ONE)
  `ASSERT_IMP(a_item_lat, clk, rst_n, out_strobe, $past(start && !busy, wcg_pkg::PIPE_LAT))
  `ASSERT_NEXT(a_busy_rel, clk, rst_n, busy, !busy)

endmodule
